FILE: rtl/lmnn_pkg.sv
// Package: shared types, constants and tables of the landmark association core.
`default_nettype none
package lmnn_pkg;

  localparam int MAP_SIZE_DEF     = 256;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES     = 24;
  localparam int CW_BITS          = 34;
  localparam int ANG_BITS         = 36;

  localparam logic signed [ANG_BITS-1:0] ANG_PI      = 36'sd3373259426;
  localparam logic signed [ANG_BITS-1:0] ANG_TWO_PI  = 36'sd6746518852;
  localparam logic signed [ANG_BITS-1:0] ANG_HALF_PI = 36'sd1686629713;
  localparam logic signed [CW_BITS-1:0]  CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [50:0]         PROJ_RND    = 51'sd2097152;
  localparam logic [61:0]                THR2_RESET  = 62'd38654705664;

  localparam logic [31:0] ATAN_TAB [ATAN_ENTRIES] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  typedef struct packed {
    logic                      vld;
    logic signed [CW_BITS-1:0] x;
    logic signed [CW_BITS-1:0] y;
    logic signed [CW_BITS-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic [7:0] idx;
    logic       added;
    logic       full;
  } scan_res_t;

  typedef enum logic [2:0] {
    T_IDLE, T_WRAP, T_CORDIC, T_ADD, T_START, T_SCAN, T_OUT
  } top_state_t;

  typedef enum logic [1:0] {
    SC_IDLE, SC_RUN, SC_DRAIN, SC_DONE
  } scan_state_t;

endpackage
`default_nettype wire

FILE: rtl/lmnn_cordic_cell.sv
// One rotation-mode CORDIC iteration, registered, for a fixed shift.
`default_nettype none
module lmnn_cordic_cell #(
  parameter int STEP = 0
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire lmnn_pkg::cordic_t  cell_in,
  output lmnn_pkg::cordic_t       cell_out
);
  import lmnn_pkg::*;

  localparam logic signed [CW_BITS-1:0] ATAN_K = CW_BITS'(signed'({1'b0, ATAN_TAB[STEP]}));

  cordic_t out_r;
  logic signed [CW_BITS-1:0] sx, sy;

  assign sx = cell_in.x >>> STEP;
  assign sy = cell_in.y >>> STEP;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.vld <= 1'b0;
    end else begin
      out_r.vld <= cell_in.vld;
    end
    if (cell_in.z >= 0) begin
      out_r.x <= cell_in.x - sy;
      out_r.y <= cell_in.y + sx;
      out_r.z <= cell_in.z - ATAN_K;
    end else begin
      out_r.x <= cell_in.x + sy;
      out_r.y <= cell_in.y - sx;
      out_r.z <= cell_in.z + ATAN_K;
    end
  end

  assign cell_out = out_r;

endmodule
`default_nettype wire

FILE: rtl/lmnn_scan.sv
// Landmark store, pipelined nearest-entry scan and append decision.
`default_nettype none
module lmnn_scan #(
  parameter int MAP_SIZE = lmnn_pkg::MAP_SIZE_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  input  wire                force_add,
  input  wire  signed [31:0] wx,
  input  wire  signed [31:0] wy,
  input  wire         [61:0] thr2,
  output logic               done,
  output lmnn_pkg::scan_res_t res
);
  import lmnn_pkg::*;

  localparam int AW = $clog2(MAP_SIZE);
  localparam int CW = $clog2(MAP_SIZE + 1);

  logic [31:0] mem_x [MAP_SIZE];
  logic [31:0] mem_y [MAP_SIZE];

  scan_state_t state_r, state_nxt;
  logic [CW-1:0] count_r, iss_r;
  logic [31:0]   rd_x_r, rd_y_r;
  logic          s1_v_r, s2_v_r, s3_v_r;
  logic [AW-1:0] s1_i_r, s2_i_r, s3_i_r;
  logic [31:0]   ax_r, ay_r;
  logic [63:0]   sq_x_r, sq_y_r;
  logic          have_r;
  logic [64:0]   best_r, sum;
  logic [AW-1:0] best_i_r;
  logic          done_r, issue, match, store;
  scan_res_t     res_r;
  logic signed [32:0] dx, dy;

  assign issue = (state_r == SC_RUN);
  assign dx    = $signed({rd_x_r[31], rd_x_r}) - $signed({wx[31], wx});
  assign dy    = $signed({rd_y_r[31], rd_y_r}) - $signed({wy[31], wy});
  assign sum   = {1'b0, sq_x_r} + {1'b0, sq_y_r};
  assign match = have_r && (best_r < {3'b000, thr2});
  assign store = (state_r == SC_DONE) && !match && (count_r < CW'(MAP_SIZE));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SC_IDLE:  if (start) state_nxt = (force_add || count_r == '0) ? SC_DONE : SC_RUN;
      SC_RUN:   if (iss_r == count_r - 1'b1) state_nxt = SC_DRAIN;
      SC_DRAIN: if (!s1_v_r && !s2_v_r && !s3_v_r) state_nxt = SC_DONE;
      SC_DONE:  state_nxt = SC_IDLE;
      default:  state_nxt = SC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SC_IDLE;
      count_r <= '0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      done_r  <= 1'b0;
      have_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      s1_v_r  <= issue;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      done_r  <= (state_r == SC_DONE);
      if (store) count_r <= count_r + 1'b1;
      if (state_r == SC_IDLE && start) begin
        have_r <= 1'b0;
      end else if (s3_v_r && (!have_r || sum < best_r)) begin
        have_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == SC_IDLE) iss_r <= '0;
    else if (issue) iss_r <= iss_r + 1'b1;
    rd_x_r <= mem_x[iss_r[AW-1:0]];
    rd_y_r <= mem_y[iss_r[AW-1:0]];
    s1_i_r <= iss_r[AW-1:0];
    s2_i_r <= s1_i_r;
    s3_i_r <= s2_i_r;
    ax_r   <= dx[32] ? 32'(-dx) : dx[31:0];
    ay_r   <= dy[32] ? 32'(-dy) : dy[31:0];
    sq_x_r <= 64'(ax_r) * 64'(ax_r);
    sq_y_r <= 64'(ay_r) * 64'(ay_r);
    if (s3_v_r && (!have_r || sum < best_r)) begin
      best_r   <= sum;
      best_i_r <= s3_i_r;
    end
    if (store) begin
      mem_x[count_r[AW-1:0]] <= wx;
      mem_y[count_r[AW-1:0]] <= wy;
    end
    if (state_r == SC_DONE) begin
      res_r.added <= store;
      res_r.full  <= !match && !store;
      if (match) res_r.idx <= 8'(best_i_r);
      else if (store) res_r.idx <= 8'(count_r);
      else res_r.idx <= 8'd0;
    end
  end

  assign done = done_r;
  assign res  = res_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAP_SIZE)) else $error("landmark count beyond map size");
  a_res_excl: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !(res_r.added && res_r.full)) else $error("added and full together");

endmodule
`default_nettype wire

FILE: rtl/landmark_nearest_neighbor_association_core.sv
// Top level: angle wrap, CORDIC cell chain, projection, scan and result register.
// Sequence: angle wrap, CORDIC chain, projection, world add, scan, result load; a forced
//   add or an empty map skips the landmark scan, and angle wrap may repeat its step.
// Throughput: one transaction at a time, the next is taken once the result is loaded.
// A new transaction is taken while the previous result still waits at the output.
// Reset: rst_n synchronous, clears landmark count and control, restores default threshold.
`default_nettype none
module landmark_nearest_neighbor_association_core #(
  parameter int MAP_SIZE     = lmnn_pkg::MAP_SIZE_DEF,
  parameter int CORDIC_STEPS = lmnn_pkg::CORDIC_STEPS_DEF
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               cfg_wr_en,
  input  wire        [30:0] cfg_wr_data,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire  signed [31:0] in_pose_x,
  input  wire  signed [31:0] in_pose_y,
  input  wire  signed [15:0] in_pose_heading,
  input  wire         [15:0] in_range,
  input  wire  signed [15:0] in_bearing,
  input  wire               in_force_add,
  output logic              out_valid,
  input  wire               out_ready,
  output logic        [7:0] out_landmark_index,
  output logic              out_added,
  output logic              out_map_full,
  output logic signed [31:0] out_world_x,
  output logic signed [31:0] out_world_y
);
  import lmnn_pkg::*;

  top_state_t state_r, state_nxt;
  logic [61:0] thr2_r;
  logic signed [31:0] pose_x_r, pose_y_r, wx_r, wy_r;
  logic [15:0] range_r;
  logic        force_r, neg_r;
  logic signed [ANG_BITS-1:0] ang_r, ang_nxt, fold;
  logic        fold_neg, launch;
  logic signed [16:0] hb;
  logic signed [50:0] px_r, py_r, rx, ry;
  logic signed [CW_BITS-1:0] xf, yf;
  cordic_t chain [CORDIC_STEPS+1];
  logic        scan_start, scan_done;
  scan_res_t   scan_res;
  logic        out_valid_r, out_load;
  logic [7:0]  o_idx_r;
  logic        o_add_r, o_full_r;
  logic signed [31:0] o_x_r, o_y_r;

  assign hb = $signed({in_pose_heading[15], in_pose_heading}) +
              $signed({in_bearing[15], in_bearing});

  always_comb begin
    fold     = ang_r;
    fold_neg = 1'b0;
    if (ang_r > ANG_HALF_PI) begin
      fold     = ang_r - ANG_PI;
      fold_neg = 1'b1;
    end else if (ang_r < -ANG_HALF_PI) begin
      fold     = ang_r + ANG_PI;
      fold_neg = 1'b1;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    ang_nxt    = ang_r;
    launch     = 1'b0;
    in_ready   = 1'b0;
    scan_start = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      T_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ang_nxt   = {hb[16], hb, 18'b0};
          state_nxt = T_WRAP;
        end
      end
      T_WRAP: begin
        if (ang_r > ANG_PI) begin
          ang_nxt = ang_r - ANG_TWO_PI;
        end else if (ang_r <= -ANG_PI) begin
          ang_nxt = ang_r + ANG_TWO_PI;
        end else begin
          launch    = 1'b1;
          state_nxt = T_CORDIC;
        end
      end
      T_CORDIC: if (chain[CORDIC_STEPS].vld) state_nxt = T_ADD;
      T_ADD:    state_nxt = T_START;
      T_START: begin
        scan_start = 1'b1;
        state_nxt  = T_SCAN;
      end
      T_SCAN:   if (scan_done) state_nxt = T_OUT;
      T_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = T_IDLE;
        end
      end
      default:  state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      thr2_r      <= THR2_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) thr2_r <= 62'(cfg_wr_data) * 62'(cfg_wr_data);
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign chain[0].vld = launch;
  assign chain[0].x   = CORDIC_GAIN;
  assign chain[0].y   = '0;
  assign chain[0].z   = CW_BITS'(fold);

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    lmnn_cordic_cell #(.STEP(g)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_in  (chain[g]),
      .cell_out (chain[g+1])
    );
  end

  assign xf = neg_r ? -chain[CORDIC_STEPS].x : chain[CORDIC_STEPS].x;
  assign yf = neg_r ? -chain[CORDIC_STEPS].y : chain[CORDIC_STEPS].y;
  assign rx = px_r + PROJ_RND;
  assign ry = py_r + PROJ_RND;

  always_ff @(posedge clk) begin
    ang_r <= ang_nxt;
    if (state_r == T_IDLE && in_valid) begin
      pose_x_r <= in_pose_x;
      pose_y_r <= in_pose_y;
      range_r  <= in_range;
      force_r  <= in_force_add;
    end
    if (launch) neg_r <= fold_neg;
    if (state_r == T_CORDIC) begin
      px_r <= 51'($signed({1'b0, range_r})) * 51'(xf);
      py_r <= 51'($signed({1'b0, range_r})) * 51'(yf);
    end
    if (state_r == T_ADD) begin
      wx_r <= pose_x_r + 32'(rx >>> 22);
      wy_r <= pose_y_r + 32'(ry >>> 22);
    end
    if (out_load) begin
      o_idx_r  <= scan_res.idx;
      o_add_r  <= scan_res.added;
      o_full_r <= scan_res.full;
      o_x_r    <= wx_r;
      o_y_r    <= wy_r;
    end
  end

  lmnn_scan #(.MAP_SIZE(MAP_SIZE)) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (scan_start),
    .force_add (force_r),
    .wx        (wx_r),
    .wy        (wy_r),
    .thr2      (thr2_r),
    .done      (scan_done),
    .res       (scan_res)
  );

  assign out_valid          = out_valid_r;
  assign out_landmark_index = o_idx_r;
  assign out_added          = o_add_r;
  assign out_map_full       = o_full_r;
  assign out_world_x        = o_x_r;
  assign out_world_y        = o_y_r;

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("second transaction taken while busy");
  a_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    scan_done |-> state_r == T_SCAN) else $error("scan finished outside scan state");

endmodule
`default_nettype wire
